@@ src/smb_pkg.sv @@
package smb_pkg;

  // request kinds as they arrive on the input tuser
  typedef enum logic [2:0] {
    OP_MEM_RD = 3'd0,
    OP_MEM_WR = 3'd1,
    OP_IO_RD  = 3'd2,
    OP_IO_WR  = 3'd3,
    OP_KEY_DN = 3'd4,
    OP_KEY_UP = 3'd5,
    OP_ROM_LD = 3'd6,
    OP_NONE   = 3'd7
  } op_t;

  // joystick key codes carried by key events
  typedef enum logic [2:0] {
    KEY_UP    = 3'd0,
    KEY_DOWN  = 3'd1,
    KEY_LEFT  = 3'd2,
    KEY_RIGHT = 3'd3,
    KEY_BTN1  = 3'd4,
    KEY_BTN2  = 3'd5,
    KEY_START = 3'd6,
    KEY_OTHER = 3'd7
  } key_t;

  // decoded i/o port classes
  typedef enum logic [2:0] {
    PORT_VIDEO,
    PORT_SND_ADDR,
    PORT_SND_WR,
    PORT_SND_RD,
    PORT_SLOT,
    PORT_KEY_ROW,
    PORT_OTHER
  } port_t;

  // primary slot codes
  typedef enum logic [1:0] {
    SLOT_BOOT  = 2'd0,
    SLOT_CART  = 2'd1,
    SLOT_EMPTY = 2'd2,
    SLOT_RAM   = 2'd3
  } slot_t;

  // where the result byte of a transfer comes from
  typedef enum logic [1:0] {
    SRC_REG,
    SRC_RAM,
    SRC_BOOT,
    SRC_CART
  } src_t;

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned MEM_DEPTH = 65536;
  localparam int unsigned STICK_W  = 6;
  localparam int unsigned SND_REGS = 16;
  localparam int unsigned SND_IDX_W = $clog2(SND_REGS);
  localparam int unsigned KEY_ROW_W = 4;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // i/o port numbers
  localparam logic [7:0] PORT_VDP_DATA = 8'h98;
  localparam logic [7:0] PORT_VDP_CTRL = 8'h99;
  localparam logic [7:0] PORT_PSG_ADDR = 8'hA0;
  localparam logic [7:0] PORT_PSG_WR   = 8'hA1;
  localparam logic [7:0] PORT_PSG_RD   = 8'hA2;
  localparam logic [7:0] PORT_PPI_A    = 8'hA8;
  localparam logic [7:0] PORT_PPI_C    = 8'hAA;

  // sound register numbers and values
  localparam logic [SND_IDX_W-1:0] SND_REG_STICK = 4'd14;
  localparam logic [SND_IDX_W-1:0] SND_REG_IOSEL = 4'd15;
  localparam logic [DATA_W-1:0]    SND_IOSEL_RESET = 8'h8F;
  localparam int unsigned          SND_IOSEL_BIT = 6;
  localparam logic [1:0]           STICK_TOP_BITS = 2'b11;
  localparam logic [STICK_W-1:0]   STICK_RELEASED = 6'h3F;

  localparam logic [DATA_W-1:0] BYTE_FF = 8'hFF;
  localparam logic [DATA_W-1:0] ROM_BLANK = 8'hFF;
  localparam logic [DATA_W-1:0] RAM_BLANK = 8'h00;

  // one classified request as it sits in the queue
  typedef struct packed {
    op_t                op;
    port_t              port;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  wdata;
    logic [STICK_W-1:0] mask;
    logic               rom_sel;
  } cmd_t;

  // back-pressure seen by the front
  typedef struct packed {
    logic q_full;
    logic clearing;
  } front_stat_t;

endpackage

@@ src/slot_mapped_bus_and_io_decoder.sv @@
// slot-mapped bus and i/o decoder
// input channel s_*: one bus request per transfer, kind in s_tuser
//   (0 mem read, 1 mem write, 2 io read, 3 io write, 4 key down,
//   5 key up, 6 rom load); address, write byte, key code and rom target
//   in s_tdata
// output channel m_*: exactly one result per request, in order; m_tdata
//   carries the read byte (zero for non-reads), m_tuser flags video ports
// path: a request passes through the queue, then the execute stage and memory
//   read, then the output register
// throughput: one request per cycle sustained while m_tready is high, set by
//   the single port of each 64 KB store, used once per request
// reset: registers return to their reset values and a clearing pass writes
//   zero to ram and 0xFF to both rom stores at all 65536 addresses, one
//   address a cycle; s_tready stays low until it ends
// stall: when m_tready is low the result holds, one more request waits in
//   the execute stage and the two-entry queue fills, then s_tready drops
module slot_mapped_bus_and_io_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // addr[15:0], wdata[23:16], key_code[26:24], rom_select[27]
  input  logic [2:0]  s_tuser,   // req_type[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // rdata[7:0]
  output logic        m_tuser    // video_port_hit[0]
);

  smb_pkg::front_stat_t stat;
  smb_pkg::cmd_t        push_cmd;
  smb_pkg::cmd_t        head_cmd;
  logic                 push;
  logic                 q_full;
  logic                 q_valid;
  logic                 q_pop;
  logic                 clearing;

  assign stat.q_full   = q_full;
  assign stat.clearing = clearing;

  // request classification
  smb_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .stat     (stat),
    .push     (push),
    .cmd      (push_cmd)
  );

  // decoupling queue
  smb_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_cmd),
    .pop   (q_pop),
    .valid (q_valid),
    .full  (q_full),
    .dout  (head_cmd)
  );

  // execution, stores and result
  smb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .cmd      (head_cmd),
    .q_pop    (q_pop),
    .clearing (clearing),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

@@ src/smb_ram.sv @@
module smb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         din,
  output logic [WIDTH-1:0]         dout
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, read data registered and held between reads
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= din;
      end else begin
        dout <= mem[addr];
      end
    end
  end

endmodule

@@ src/smb_front.sv @@
module smb_front (
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,
  input  logic [2:0]            s_tuser,
  input  smb_pkg::front_stat_t  stat,
  output logic                  push,
  output smb_pkg::cmd_t         cmd
);

  logic [7:0]    port_num;
  smb_pkg::key_t key_code;

  assign s_tready = !stat.q_full && !stat.clearing;
  assign push     = s_tvalid && s_tready;
  assign port_num = s_tdata[7:0];
  assign key_code = smb_pkg::key_t'(s_tdata[26:24]);

  // classify the incoming transfer
  always_comb begin
    cmd.op      = smb_pkg::op_t'(s_tuser);
    cmd.addr    = s_tdata[15:0];
    cmd.wdata   = s_tdata[23:16];
    cmd.rom_sel = s_tdata[27];

    unique case (port_num)
      smb_pkg::PORT_VDP_DATA,
      smb_pkg::PORT_VDP_CTRL: cmd.port = smb_pkg::PORT_VIDEO;
      smb_pkg::PORT_PSG_ADDR: cmd.port = smb_pkg::PORT_SND_ADDR;
      smb_pkg::PORT_PSG_WR:   cmd.port = smb_pkg::PORT_SND_WR;
      smb_pkg::PORT_PSG_RD:   cmd.port = smb_pkg::PORT_SND_RD;
      smb_pkg::PORT_PPI_A:    cmd.port = smb_pkg::PORT_SLOT;
      smb_pkg::PORT_PPI_C:    cmd.port = smb_pkg::PORT_KEY_ROW;
      default:                cmd.port = smb_pkg::PORT_OTHER;
    endcase

    // joystick bit for a key event; button2 and start share a bit
    unique case (key_code)
      smb_pkg::KEY_UP:    cmd.mask = 6'h01;
      smb_pkg::KEY_DOWN:  cmd.mask = 6'h02;
      smb_pkg::KEY_LEFT:  cmd.mask = 6'h04;
      smb_pkg::KEY_RIGHT: cmd.mask = 6'h08;
      smb_pkg::KEY_BTN1:  cmd.mask = 6'h10;
      smb_pkg::KEY_BTN2,
      smb_pkg::KEY_START: cmd.mask = 6'h20;
      default:            cmd.mask = 6'h00;
    endcase
  end

endmodule

@@ src/smb_queue.sv @@
module smb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  smb_pkg::cmd_t din,
  input  logic          pop,
  output logic          valid,
  output logic          full,
  output smb_pkg::cmd_t dout
);

  smb_pkg::cmd_t                  slots [smb_pkg::QDEPTH];
  logic [smb_pkg::QPTR_W-1:0]     wr_ptr;
  logic [smb_pkg::QPTR_W-1:0]     rd_ptr;
  logic [smb_pkg::QCNT_W-1:0]     count;

  assign valid = (count != '0);
  assign full  = (count == smb_pkg::QCNT_W'(smb_pkg::QDEPTH));
  assign dout  = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == smb_pkg::QPTR_W'(smb_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == smb_pkg::QPTR_W'(smb_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !valid |-> !pop)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= smb_pkg::QCNT_W'(smb_pkg::QDEPTH))
    else $error("queue count out of range");
`endif

endmodule

@@ src/smb_back.sv @@
module smb_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  smb_pkg::cmd_t cmd,
  output logic          q_pop,
  output logic          clearing,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [7:0]    m_tdata,
  output logic          m_tuser
);

  localparam int unsigned AW = smb_pkg::ADDR_W;
  localparam int unsigned DW = smb_pkg::DATA_W;

  // architectural registers
  smb_pkg::slot_t                page_slot [4];
  logic [DW-1:0]                 sound_regs [smb_pkg::SND_REGS];
  logic [smb_pkg::SND_IDX_W-1:0] sound_latch;
  logic [smb_pkg::KEY_ROW_W-1:0] key_row;
  logic [smb_pkg::STICK_W-1:0]   stick_one;
  logic [smb_pkg::STICK_W-1:0]   stick_next;

  // clearing pass
  logic [AW-1:0] clr_addr;

  // pending stage and output register
  logic          pend_valid;
  smb_pkg::src_t pend_src;
  logic [DW-1:0] pend_rd;
  logic          pend_vhit;
  smb_pkg::src_t pend_src_next;
  logic [DW-1:0] pend_rd_next;
  logic          pend_vhit_next;
  logic          pend_leave;
  logic [DW-1:0] result;

  // decoded actions
  smb_pkg::slot_t cur_slot;
  logic           mem_rd;
  logic           ram_wr;
  logic           boot_wr;
  logic           cart_wr;
  logic           slot_wr;
  logic           latch_wr;
  logic           snd_wr;
  logic           keyrow_wr;
  logic [DW-1:0]  snd_rd;
  logic [DW-1:0]  slot_packed;

  // memory ports
  logic          ram_en;
  logic          ram_we;
  logic          boot_en;
  logic          boot_we;
  logic          cart_en;
  logic          cart_we;
  logic [AW-1:0] mem_addr;
  logic [DW-1:0] ram_dout;
  logic [DW-1:0] boot_dout;
  logic [DW-1:0] cart_dout;

  assign pend_leave = pend_valid && (!m_tvalid || m_tready);
  assign q_pop      = q_valid && !clearing && (!pend_valid || pend_leave);
  assign cur_slot   = page_slot[cmd.addr[AW-1:AW-2]];

  assign slot_packed = {page_slot[3], page_slot[2], page_slot[1], page_slot[0]};

  // sound register read, with the joystick behind register 14
  always_comb begin
    if (sound_latch != smb_pkg::SND_REG_STICK) begin
      snd_rd = sound_regs[sound_latch];
    end else if (!sound_regs[smb_pkg::SND_REG_IOSEL][smb_pkg::SND_IOSEL_BIT]) begin
      snd_rd = {smb_pkg::STICK_TOP_BITS, stick_one};
    end else begin
      snd_rd = {smb_pkg::STICK_TOP_BITS, smb_pkg::STICK_RELEASED};
    end
  end

  // execute the head command
  always_comb begin
    pend_src_next  = smb_pkg::SRC_REG;
    pend_rd_next   = '0;
    pend_vhit_next = 1'b0;
    mem_rd         = 1'b0;
    ram_wr         = 1'b0;
    boot_wr        = 1'b0;
    cart_wr        = 1'b0;
    slot_wr        = 1'b0;
    latch_wr       = 1'b0;
    snd_wr         = 1'b0;
    keyrow_wr      = 1'b0;
    stick_next     = stick_one;
    unique case (cmd.op)
      smb_pkg::OP_MEM_RD: begin
        mem_rd = 1'b1;
        unique case (cur_slot)
          smb_pkg::SLOT_BOOT:  pend_src_next = smb_pkg::SRC_BOOT;
          smb_pkg::SLOT_CART:  pend_src_next = smb_pkg::SRC_CART;
          smb_pkg::SLOT_RAM:   pend_src_next = smb_pkg::SRC_RAM;
          default:             pend_rd_next  = smb_pkg::BYTE_FF;
        endcase
      end
      smb_pkg::OP_MEM_WR: begin
        ram_wr = (cur_slot == smb_pkg::SLOT_RAM);
      end
      smb_pkg::OP_IO_RD: begin
        unique case (cmd.port)
          smb_pkg::PORT_VIDEO:   pend_vhit_next = 1'b1;
          smb_pkg::PORT_SND_RD:  pend_rd_next   = snd_rd;
          smb_pkg::PORT_SLOT:    pend_rd_next   = slot_packed;
          smb_pkg::PORT_KEY_ROW: pend_rd_next   = {{(DW - smb_pkg::KEY_ROW_W){1'b0}}, key_row};
          default:               pend_rd_next   = smb_pkg::BYTE_FF;
        endcase
      end
      smb_pkg::OP_IO_WR: begin
        unique case (cmd.port)
          smb_pkg::PORT_VIDEO:    pend_vhit_next = 1'b1;
          smb_pkg::PORT_SND_ADDR: latch_wr       = 1'b1;
          smb_pkg::PORT_SND_WR:   snd_wr         = (sound_latch != smb_pkg::SND_REG_STICK);
          smb_pkg::PORT_SLOT:     slot_wr        = 1'b1;
          smb_pkg::PORT_KEY_ROW:  keyrow_wr      = 1'b1;
          default: ;
        endcase
      end
      smb_pkg::OP_KEY_DN: stick_next = stick_one & ~cmd.mask;
      smb_pkg::OP_KEY_UP: stick_next = stick_one | cmd.mask;
      smb_pkg::OP_ROM_LD: begin
        cart_wr = cmd.rom_sel;
        boot_wr = !cmd.rom_sel;
      end
      default: ;
    endcase
  end

  // register file updates and clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      page_slot[0] <= smb_pkg::SLOT_BOOT;
      page_slot[1] <= smb_pkg::SLOT_BOOT;
      page_slot[2] <= smb_pkg::SLOT_RAM;
      page_slot[3] <= smb_pkg::SLOT_RAM;
      for (int i = 0; i < smb_pkg::SND_REGS; i++) begin
        sound_regs[i] <= (i == int'(smb_pkg::SND_REG_IOSEL)) ? smb_pkg::SND_IOSEL_RESET : '0;
      end
      sound_latch <= '0;
      key_row     <= '0;
      stick_one   <= smb_pkg::STICK_RELEASED;
      clearing    <= 1'b1;
      clr_addr    <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == '1) begin
          clearing <= 1'b0;
        end
      end
      if (q_pop) begin
        stick_one <= stick_next;
        if (slot_wr) begin
          for (int p = 0; p < 4; p++) begin
            page_slot[p] <= smb_pkg::slot_t'(cmd.wdata[2*p +: 2]);
          end
        end
        if (latch_wr) begin
          sound_latch <= cmd.wdata[smb_pkg::SND_IDX_W-1:0];
        end
        if (snd_wr) begin
          sound_regs[sound_latch] <= cmd.wdata;
        end
        if (keyrow_wr) begin
          key_row <= cmd.wdata[smb_pkg::KEY_ROW_W-1:0];
        end
      end
    end
  end

  // pending stage holds an executed command while its registered memory read data comes out
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (q_pop) begin
      pend_valid <= 1'b1;
    end else if (pend_leave) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pend_src  <= pend_src_next;
      pend_rd   <= pend_rd_next;
      pend_vhit <= pend_vhit_next;
    end
  end

  // result byte selection
  always_comb begin
    unique case (pend_src)
      smb_pkg::SRC_RAM:  result = ram_dout;
      smb_pkg::SRC_BOOT: result = boot_dout;
      smb_pkg::SRC_CART: result = cart_dout;
      default:           result = pend_rd;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pend_leave) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_leave) begin
      m_tdata <= result;
      m_tuser <= pend_vhit;
    end
  end

  // memory port drive, the clearing pass owns all three ports
  assign mem_addr = clearing ? clr_addr : cmd.addr;
  assign ram_en   = clearing || (q_pop && (mem_rd || ram_wr));
  assign ram_we   = clearing || ram_wr;
  assign boot_en  = clearing || (q_pop && (mem_rd || boot_wr));
  assign boot_we  = clearing || boot_wr;
  assign cart_en  = clearing || (q_pop && (mem_rd || cart_wr));
  assign cart_we  = clearing || cart_wr;

  smb_ram #(.WIDTH(DW), .DEPTH(smb_pkg::MEM_DEPTH)) u_main_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (mem_addr),
    .din  (clearing ? smb_pkg::RAM_BLANK : cmd.wdata),
    .dout (ram_dout)
  );

  smb_ram #(.WIDTH(DW), .DEPTH(smb_pkg::MEM_DEPTH)) u_boot_rom (
    .clk  (clk),
    .en   (boot_en),
    .we   (boot_we),
    .addr (mem_addr),
    .din  (clearing ? smb_pkg::ROM_BLANK : cmd.wdata),
    .dout (boot_dout)
  );

  smb_ram #(.WIDTH(DW), .DEPTH(smb_pkg::MEM_DEPTH)) u_cart_rom (
    .clk  (clk),
    .en   (cart_en),
    .we   (cart_we),
    .addr (mem_addr),
    .din  (clearing ? smb_pkg::ROM_BLANK : cmd.wdata),
    .dout (cart_dout)
  );

`ifndef SYNTHESIS
  a_no_pop_clearing: assert property (@(posedge clk) disable iff (rst) clearing |-> !q_pop)
    else $error("command executed during clearing pass");
  a_pend_holds: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && !pend_leave) |=> (pend_valid && $stable(pend_src) && $stable(pend_rd)))
    else $error("pending result lost while output stalled");
  a_video_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == 8'h00))
    else $error("video port result carries data");
  a_stick_reg_ro: assert property (@(posedge clk) disable iff (rst)
    sound_regs[smb_pkg::SND_REG_STICK] == 8'h00)
    else $error("read-only sound register written");
`endif

endmodule

@@ verif/smb_checker.sv @@
`timescale 1ns / 1ps

// watches both channels of the bus decoder, predicts every result from
// its own copy of the bus state and compares results in order
module smb_checker
  import smb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,     // addr[15:0], wdata[23:16], key_code[26:24], rom_select[27]
  input  logic [2:0]  s_tuser,     // req_type[2:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,     // rdata[7:0]
  input  logic        m_tuser,     // video_port_hit[0]
  output int          errors,
  output int          outstanding
);

  typedef struct packed {
    logic [7:0] rdata;
    logic       vhit;
  } bus_result_t;

  // local image of the bus state
  logic [7:0] ram_img  [0:MEM_DEPTH-1];
  logic [7:0] boot_img [0:MEM_DEPTH-1];
  logic [7:0] cart_img [0:MEM_DEPTH-1];
  slot_t      page_map [0:3];
  logic [7:0] psg_regs [0:SND_REGS-1];
  logic [3:0] psg_latch;
  logic [3:0] kb_row;
  logic [5:0] joy_a;

  bus_result_t bus_results_due [$];
  bus_result_t due_res;
  bus_result_t new_res;
  int          fail_count = 0;
  int          due_count = 0;
  int          i;

  assign errors      = fail_count;
  assign outstanding = due_count;

  // one line per mismatch
  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("mismatch %s at %0t: expected %h, got %h", what, $time, want, got);
    fail_count++;
  endtask

  // expected result of one bus request, updating the bus state
  task automatic bus_decode(input op_t op, input logic [15:0] a, input logic [7:0] d,
                            input logic [2:0] key, input logic sel,
                            output bus_result_t res);
    logic [5:0] bit_sel;
    logic [3:0] reg_no;
    slot_t      sl;
    res    = '0;
    sl     = page_map[a[15:14]];
    reg_no = psg_latch;
    case (key_t'(key))
      KEY_UP:              bit_sel = 6'h01;
      KEY_DOWN:            bit_sel = 6'h02;
      KEY_LEFT:            bit_sel = 6'h04;
      KEY_RIGHT:           bit_sel = 6'h08;
      KEY_BTN1:            bit_sel = 6'h10;
      KEY_BTN2, KEY_START: bit_sel = 6'h20;
      default:             bit_sel = 6'h00;
    endcase
    case (op)
      OP_MEM_RD: begin
        case (sl)
          SLOT_BOOT:  res.rdata = boot_img[a];
          SLOT_CART:  res.rdata = cart_img[a];
          SLOT_EMPTY: res.rdata = BYTE_FF;
          default:    res.rdata = ram_img[a];
        endcase
      end
      OP_MEM_WR: begin
        // only ram takes writes
        if (sl == SLOT_RAM)
          ram_img[a] = d;
      end
      OP_IO_RD: begin
        case (a[7:0])
          PORT_VDP_DATA, PORT_VDP_CTRL: res.vhit = 1'b1;
          PORT_PSG_RD: begin
            // register 14 reads back a joystick picked by register 15
            if (reg_no != SND_REG_STICK)
              res.rdata = psg_regs[reg_no];
            else if (!psg_regs[SND_REG_IOSEL][SND_IOSEL_BIT])
              res.rdata = {STICK_TOP_BITS, joy_a};
            else
              res.rdata = BYTE_FF;
          end
          PORT_PPI_A: res.rdata = {page_map[3], page_map[2], page_map[1], page_map[0]};
          PORT_PPI_C: res.rdata = {4'h0, kb_row};
          default:    res.rdata = BYTE_FF;
        endcase
      end
      OP_IO_WR: begin
        case (a[7:0])
          PORT_VDP_DATA, PORT_VDP_CTRL: res.vhit = 1'b1;
          PORT_PSG_ADDR: psg_latch = d[3:0];
          PORT_PSG_WR: begin
            if (reg_no != SND_REG_STICK)
              psg_regs[reg_no] = d;
          end
          PORT_PPI_A: begin
            page_map[0] = slot_t'(d[1:0]);
            page_map[1] = slot_t'(d[3:2]);
            page_map[2] = slot_t'(d[5:4]);
            page_map[3] = slot_t'(d[7:6]);
          end
          PORT_PPI_C: kb_row = d[3:0];
          default: ;
        endcase
      end
      OP_KEY_DN: joy_a = joy_a & ~bit_sel;
      OP_KEY_UP: joy_a = joy_a | bit_sel;
      OP_ROM_LD: begin
        if (sel)
          cart_img[a] = d;
        else
          boot_img[a] = d;
      end
      default: ;
    endcase
  endtask

  // reset image, then check results and predict on every transfer
  always @(posedge clk) begin
    if (rst) begin
      for (i = 0; i < MEM_DEPTH; i++) begin
        ram_img[i]  = RAM_BLANK;
        boot_img[i] = ROM_BLANK;
        cart_img[i] = ROM_BLANK;
      end
      page_map[0] = SLOT_BOOT;
      page_map[1] = SLOT_BOOT;
      page_map[2] = SLOT_RAM;
      page_map[3] = SLOT_RAM;
      for (i = 0; i < SND_REGS; i++)
        psg_regs[i] = 8'h00;
      psg_regs[SND_REG_IOSEL] = SND_IOSEL_RESET;
      psg_latch = '0;
      kb_row    = '0;
      joy_a     = STICK_RELEASED;
      bus_results_due.delete();
    end else begin
      // result side
      if (m_tvalid && m_tready) begin
        if (bus_results_due.size() == 0) begin
          report_mismatch("result with nothing due", 8'h00, m_tdata);
        end else begin
          due_res = bus_results_due.pop_front();
          if (m_tdata !== due_res.rdata)
            report_mismatch("read byte", due_res.rdata, m_tdata);
          if (m_tuser !== due_res.vhit)
            report_mismatch("video port flag", {7'h0, due_res.vhit}, {7'h0, m_tuser});
        end
      end
      // request side
      if (s_tvalid && s_tready) begin
        bus_decode(op_t'(s_tuser), s_tdata[15:0], s_tdata[23:16], s_tdata[26:24],
                   s_tdata[27], new_res);
        bus_results_due.push_back(new_res);
      end
    end
    due_count <= bus_results_due.size();
  end

endmodule

@@ verif/tb_slot_mapped_bus_and_io_decoder.sv @@
`timescale 1ns / 1ps

module tb_slot_mapped_bus_and_io_decoder;
  import smb_pkg::*;

  // ports the block has no name for
  localparam logic [7:0] PORT_KEY_MATRIX = 8'hA9;
  localparam logic [7:0] PORT_UNUSED     = 8'h12;
  // covers the clearing pass plus a slow stalled run, several times
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 430;

  typedef struct {
    op_t         op;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [2:0]  key;
    logic        sel;
  } bus_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;    // addr[15:0], wdata[23:16], key_code[26:24], rom_select[27]
  logic [2:0]  s_tuser = '0;    // req_type[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // rdata[7:0]
  logic        m_tuser;         // video_port_hit[0]

  int   errors;
  int   outstanding;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  logic hold_off = 1'b0;
  int   cycle_count = 0;

  slot_mapped_bus_and_io_decoder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  smb_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (rst)
      m_tready <= 1'b0;
    else
      m_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // offer one request, with random idle cycles first, until it transfers
  task automatic send_req(input bus_req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req.op;
    s_tdata  <= {4'h0, req.sel, req.key, req.wdata, req.addr};
    do
      @(posedge clk);
    while (!s_tready);
  endtask

  task automatic put(input op_t op, input logic [15:0] addr, input logic [7:0] wdata,
                     input logic [2:0] key, input logic sel);
    bus_req_t req;
    req.op    = op;
    req.addr  = addr;
    req.wdata = wdata;
    req.key   = key;
    req.sel   = sel;
    send_req(req);
  endtask

  // random request: addresses mostly from a small pool so reads hit earlier writes
  function automatic bus_req_t random_request();
    bus_req_t    req;
    int          pick;
    logic [7:0]  port;
    logic [15:0] pool_addr;
    pick      = $urandom_range(99);
    req.wdata = 8'($urandom);
    req.key   = 3'($urandom_range(7));
    req.sel   = 1'($urandom_range(1));
    pool_addr = {2'($urandom_range(3)), 10'h000, 4'($urandom_range(15))};
    if ($urandom_range(3) == 0)
      req.addr = 16'($urandom);
    else
      req.addr = pool_addr;
    if (pick < 30)      req.op = OP_MEM_RD;
    else if (pick < 50) req.op = OP_MEM_WR;
    else if (pick < 65) req.op = OP_IO_RD;
    else if (pick < 80) req.op = OP_IO_WR;
    else if (pick < 86) req.op = OP_KEY_DN;
    else if (pick < 92) req.op = OP_KEY_UP;
    else if (pick < 99) req.op = OP_ROM_LD;
    else                req.op = OP_NONE;
    // i/o requests mostly hit decoded ports, upper address byte random
    if (req.op == OP_IO_RD || req.op == OP_IO_WR) begin
      case ($urandom_range(9))
        0:       port = PORT_VDP_DATA;
        1:       port = PORT_VDP_CTRL;
        2:       port = PORT_PSG_ADDR;
        3:       port = PORT_PSG_WR;
        4, 5:    port = PORT_PSG_RD;
        6:       port = PORT_PPI_A;
        7:       port = PORT_KEY_MATRIX;
        8:       port = PORT_PPI_C;
        default: port = 8'($urandom);
      endcase
      req.addr = {8'($urandom), port};
    end
    return req;
  endfunction

  task automatic random_burst(input int count);
    for (int n = 0; n < count; n++)
      send_req(random_request());
  endtask

  // stimulus
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: reset slot map, slot routing and ignored writes
    put(OP_IO_RD,  16'h00A8, 8'h00, 3'd0, 1'b0);
    put(OP_MEM_RD, 16'h0000, 8'h00, 3'd0, 1'b0);
    put(OP_MEM_WR, 16'hC000, 8'h5A, 3'd0, 1'b0);
    put(OP_MEM_RD, 16'hC000, 8'h00, 3'd7, 1'b1);
    put(OP_MEM_WR, 16'h0000, 8'h11, 3'd0, 1'b0);
    put(OP_ROM_LD, 16'h0000, 8'h00, 3'd0, 1'b0);
    put(OP_ROM_LD, 16'hFFFF, 8'hA5, 3'd7, 1'b1);
    put(OP_IO_WR,  16'hFFA8, 8'hE4, 3'd0, 1'b0);
    put(OP_MEM_RD, 16'h0000, 8'hFF, 3'd0, 1'b0);
    put(OP_MEM_WR, 16'h8000, 8'h77, 3'd0, 1'b0);
    put(OP_MEM_RD, 16'h8000, 8'h00, 3'd0, 1'b0);
    put(OP_IO_WR,  16'h00A8, 8'h55, 3'd0, 1'b0);
    put(OP_MEM_RD, 16'hFFFF, 8'h00, 3'd0, 1'b0);
    put(OP_IO_WR,  16'h00A8, 8'hFF, 3'd0, 1'b0);
    // video ports
    put(OP_IO_WR,  16'h1200 | 16'(PORT_VDP_DATA), 8'hFF, 3'd0, 1'b0);
    put(OP_IO_RD,  16'hFF00 | 16'(PORT_VDP_CTRL), 8'h00, 3'd0, 1'b0);
    // read-only stick register and joystick bits
    put(OP_IO_WR,  16'(PORT_PSG_ADDR), 8'hFE, 3'd0, 1'b0);
    put(OP_IO_WR,  16'(PORT_PSG_WR),   8'h33, 3'd0, 1'b0);
    for (int k = 1; k < 8; k += 3)
      put(OP_KEY_DN, 16'h0000, 8'h00, 3'(k), 1'b0);
    put(OP_IO_RD,  16'(PORT_PSG_RD),   8'h00, 3'd0, 1'b0);
    // second joystick selected by register 15
    put(OP_IO_WR,  16'(PORT_PSG_ADDR), 8'h0F, 3'd0, 1'b0);
    put(OP_IO_WR,  16'(PORT_PSG_WR),   8'h40, 3'd0, 1'b0);
    put(OP_IO_WR,  16'(PORT_PSG_ADDR), 8'h0E, 3'd0, 1'b0);
    put(OP_IO_RD,  16'(PORT_PSG_RD),   8'h00, 3'd0, 1'b0);
    // keyboard row, key matrix, unused port, unused request kind
    put(OP_IO_WR,  16'(PORT_PPI_C),      8'hF7, 3'd0, 1'b0);
    put(OP_IO_RD,  16'(PORT_PPI_C),      8'h00, 3'd0, 1'b0);
    put(OP_IO_RD,  16'(PORT_KEY_MATRIX), 8'h00, 3'd0, 1'b0);
    put(OP_IO_RD,  16'(PORT_UNUSED),     8'h00, 3'd0, 1'b0);
    put(OP_NONE,   16'hFFFF, 8'hFF, 3'd7, 1'b1);

    // random, no idling on either side
    random_burst(PHASE_ITEMS);

    // long receiver hold-off while requests keep coming
    fork
      begin
        hold_off <= 1'b1;
        repeat (80) @(posedge clk);
        hold_off <= 1'b0;
      end
      random_burst(40);
    join

    // sender idles
    send_idle_pct <= 48;
    random_burst(PHASE_ITEMS);

    // pause until every result is back
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);

    // receiver stalls
    send_idle_pct <= 0;
    stall_pct     <= 48;
    random_burst(PHASE_ITEMS);

    // both sides idle
    send_idle_pct <= 28;
    stall_pct     <= 28;
    random_burst(PHASE_ITEMS);

    // drain and let the pipeline settle
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

@@ filelist.f @@
src/smb_pkg.sv
src/smb_ram.sv
src/smb_front.sv
src/smb_queue.sv
src/smb_back.sv
src/slot_mapped_bus_and_io_decoder.sv
verif/smb_checker.sv
verif/tb_slot_mapped_bus_and_io_decoder.sv
